[hw/rtl/stfl_pkg.sv]
// stfl_pkg: types and constants for the sample table frame locator
// word layouts of the input and result channels, item kinds, register indexes
// no dependencies
package stfl_pkg;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SCNT_W     = 13;
    localparam int CCNT_W     = 11;
    localparam int GCNT_W     = 7;

    localparam logic [1:0] KIND_WR_SIZE   = 2'd0;
    localparam logic [1:0] KIND_WR_CHUNK  = 2'd1;
    localparam logic [1:0] KIND_WR_GROUP  = 2'd2;
    localparam logic [1:0] KIND_LOOKUP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] table_index;
        logic [63:0] entry_value;
        logic [31:0] group_samples;
        logic [31:0] sample_number;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [63:0] byte_offset;
        logic [31:0] frame_size;
    } t_out_word;

endpackage

[hw/rtl/sample_table_frame_locator_unit.sv]
// sample_table_frame_locator_unit: three table memories and a lookup walker; uses stfl_pkg
// Lookup: a sample past the table goes straight to the result; else its size is read and
// chunks are walked, with a wait state after a group change, until one holds the sample
// or they run out; a hit then sums the sizes from the chunk start up to the sample.
// One load word per cycle when idle; one lookup at a time, held until its result is set.
// Reset: synchronous active low; clears counts, sequencer, output valid; tables are not cleared.
module sample_table_frame_locator_unit
    import stfl_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int MAX_CHUNKS  = 1024,
    parameter int MAX_GROUPS  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data
);

    localparam int SA_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CA_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int GA_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SIZE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_GWAIT = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // configuration
    logic [SCNT_W-1:0] r_sample_count;
    logic [CCNT_W-1:0] r_chunk_count;
    logic [GCNT_W-1:0] r_group_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_chunk_count  <= '0;
            r_group_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[SCNT_W-1:0];
                CFG_CHUNK_COUNT:  r_chunk_count  <= i_cfg_data[CCNT_W-1:0];
                CFG_GROUP_COUNT:  r_group_count  <= i_cfg_data[GCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // counts above the table depth act as the depth
    logic [SCNT_W-1:0] ns;
    logic [CCNT_W-1:0] nch;
    logic [GCNT_W-1:0] ngr;

    always_comb begin
        ns  = (32'(r_sample_count) > MAX_SAMPLES) ? SCNT_W'(MAX_SAMPLES) : r_sample_count;
        nch = (32'(r_chunk_count) > MAX_CHUNKS) ? CCNT_W'(MAX_CHUNKS) : r_chunk_count;
        ngr = (32'(r_group_count) > MAX_GROUPS) ? GCNT_W'(MAX_GROUPS) : r_group_count;
    end

    // sequencer registers
    logic [2:0]        r_state, n_state;
    logic [31:0]       r_s, n_s;
    logic [31:0]       r_base, n_base;
    logic [31:0]       r_spc, n_spc;
    logic [GCNT_W-1:0] r_gi, n_gi;
    logic [CCNT_W-1:0] r_nc, n_nc;
    logic [31:0]       r_k, n_k;
    logic              r_pend, n_pend;
    logic [63:0]       r_sum, n_sum;
    logic              r_found, n_found;
    logic [63:0]       r_off, n_off;
    logic [31:0]       r_size, n_size;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    // memories
    logic [31:0] r_smp_mem [MAX_SAMPLES];
    logic [63:0] r_chk_mem [MAX_CHUNKS];
    logic [63:0] r_grp_mem [MAX_GROUPS];
    logic [31:0] r_smp_rdata;
    logic [63:0] r_chk_rdata;
    logic [63:0] r_grp_rdata;

    logic            in_acc;
    logic [31:0]     idx_ext;
    logic            smp_we, chk_we, grp_we;
    logic [SA_W-1:0] smp_ra;
    logic [CA_W-1:0] chk_ra;
    logic [GA_W-1:0] grp_ra;
    logic [GCNT_W:0] gi_nxt;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign idx_ext    = 32'(i_in_data.table_index);
    assign smp_we     = in_acc && (i_in_data.kind == KIND_WR_SIZE) && (idx_ext < MAX_SAMPLES);
    assign chk_we     = in_acc && (i_in_data.kind == KIND_WR_CHUNK) && (idx_ext < MAX_CHUNKS);
    assign grp_we     = in_acc && (i_in_data.kind == KIND_WR_GROUP) && (idx_ext < MAX_GROUPS);
    assign gi_nxt     = {1'b0, r_gi} + (GCNT_W+1)'(1);

    // the sample port serves the frame size read at accept, then the sum walk
    assign smp_ra = (r_state == S_IDLE) ? SA_W'(i_in_data.sample_number) : SA_W'(r_k);
    assign chk_ra = CA_W'(r_nc);
    // group 0 is read at accept; during the walk the port looks one group ahead
    assign grp_ra = (r_state == S_IDLE) ? '0 : GA_W'(gi_nxt);

    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            r_smp_mem[SA_W'(idx_ext)] <= i_in_data.entry_value[31:0];
        end
        r_smp_rdata <= r_smp_mem[smp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (chk_we) begin
            r_chk_mem[CA_W'(idx_ext)] <= i_in_data.entry_value;
        end
        r_chk_rdata <= r_chk_mem[chk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (grp_we) begin
            r_grp_mem[GA_W'(idx_ext)] <= {i_in_data.entry_value[31:0], i_in_data.group_samples};
        end
        r_grp_rdata <= r_grp_mem[grp_ra];
    end

    // walk step
    logic        adv;
    logic [31:0] cur_spc;
    logic [32:0] limit;
    logic        hit;
    logic [CCNT_W:0] nc_nxt;

    always_comb begin
        adv     = (gi_nxt < {1'b0, ngr})
                  && (32'(r_nc) == (r_grp_rdata[63:32] - 32'd1));
        cur_spc = adv ? r_grp_rdata[31:0] : r_spc;
        limit   = {1'b0, r_base} + {1'b0, cur_spc};
        hit     = {1'b0, r_s} < limit;
        nc_nxt  = {1'b0, r_nc} + (CCNT_W+1)'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_s         = r_s;
        n_base      = r_base;
        n_spc       = r_spc;
        n_gi        = r_gi;
        n_nc        = r_nc;
        n_k         = r_k;
        n_pend      = r_pend;
        n_sum       = r_sum;
        n_found     = r_found;
        n_off       = r_off;
        n_size      = r_size;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.kind == KIND_LOOKUP)) begin
                    n_s     = i_in_data.sample_number;
                    n_gi    = '0;
                    n_nc    = '0;
                    n_base  = '0;
                    n_found = 1'b0;
                    n_off   = '0;
                    n_size  = '0;
                    if (i_in_data.sample_number >= 32'(ns)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SIZE;
                    end
                end
            end
            S_SIZE: begin
                n_size = r_smp_rdata;
                n_spc  = (ngr == '0) ? 32'd1 : r_grp_rdata[31:0];
                if (nch == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (adv) begin
                    n_gi  = GCNT_W'(gi_nxt);
                    n_spc = r_grp_rdata[31:0];
                end
                if (hit) begin
                    n_k     = r_base;
                    n_pend  = 1'b0;
                    n_sum   = '0;
                    n_state = S_SUM;
                end else begin
                    n_base = limit[31:0];
                    n_nc   = CCNT_W'(nc_nxt);
                    if (nc_nxt == {1'b0, nch}) begin
                        n_state = S_OUT;
                    end else if (adv) begin
                        n_state = S_GWAIT;
                    end
                end
            end
            S_GWAIT: begin
                // group port re-reads one group ahead of the new index
                n_state = S_WALK;
            end
            S_SUM: begin
                if (r_pend) begin
                    n_sum = r_sum + 64'(r_smp_rdata);
                end
                if (r_k < r_s) begin
                    n_k    = r_k + 32'd1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_found = 1'b1;
                        n_off   = r_chk_rdata + r_sum;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.found       = r_found;
                    n_out.byte_offset = r_off;
                    n_out.frame_size  = r_size;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_base  <= n_base;
        r_spc   <= n_spc;
        r_gi    <= n_gi;
        r_nc    <= n_nc;
        r_k     <= n_k;
        r_sum   <= n_sum;
        r_found <= n_found;
        r_off   <= n_off;
        r_size  <= n_size;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[verif/tb_sample_table_frame_locator_unit.sv]
`timescale 1ns / 100ps
// tb_sample_table_frame_locator_unit: self-checking bench for the sample table frame locator
// mirrors the size, chunk offset and group tables and walks them to predict every lookup word
// depends on stfl_pkg and sample_table_frame_locator_unit
module tb_sample_table_frame_locator_unit;
    import stfl_pkg::*;

    localparam int SIZE_DEPTH    = 4096;
    localparam int CHUNK_DEPTH   = 1024;
    localparam int GROUP_DEPTH   = 64;
    localparam int ITEM_TARGET   = 290;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int MAX_REPORTS   = 10;

    typedef enum int unsigned {RX_ALWAYS, RX_RANDOM, RX_CHOPPY, RX_SLUGGISH} t_rx_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_data;

    // shadow copy of the block's tables and count registers
    bit [31:0] size_tbl      [SIZE_DEPTH];
    bit [63:0] offset_tbl    [CHUNK_DEPTH];
    bit [31:0] grp_first_tbl [GROUP_DEPTH];
    bit [31:0] grp_spc_tbl   [GROUP_DEPTH];
    bit        size_known    [SIZE_DEPTH];
    bit        offset_known  [CHUNK_DEPTH];
    bit        grp_known     [GROUP_DEPTH];
    bit [12:0] n_samples_reg;
    bit [10:0] n_chunks_reg;
    bit [6:0]  n_groups_reg;

    t_out_word   located_q [$];
    int unsigned words_counted = 0;
    int unsigned loads_done    = 0;
    int unsigned lookups_done  = 0;
    int unsigned hits          = 0;
    int unsigned mismatches    = 0;
    int unsigned settings_used = 0;
    int unsigned burst_left    = 0;
    bit          steady        = 1'b1;
    t_rx_mode    ready_mode    = RX_ALWAYS;
    int unsigned stall_tick    = 0;

    sample_table_frame_locator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("tb_sample_table_frame_locator_unit: done, errors");
        $finish;
    end

    // walk the chunks for sample s; clean drops if any entry read was never loaded
    function automatic t_out_word locate_sample(input bit [31:0] s, output bit clean);
        int unsigned ns, nch, ng, gi, nc, k;
        bit [63:0]   base, spc, sum;
        t_out_word   loc;
        loc   = '0;
        clean = 1'b1;
        ns    = (n_samples_reg > SIZE_DEPTH) ? SIZE_DEPTH : n_samples_reg;
        nch   = (n_chunks_reg > CHUNK_DEPTH) ? CHUNK_DEPTH : n_chunks_reg;
        ng    = (n_groups_reg > GROUP_DEPTH) ? GROUP_DEPTH : n_groups_reg;
        if (s >= ns) return loc;
        clean &= size_known[s[11:0]];
        loc.frame_size = size_tbl[s[11:0]];
        if (nch == 0) return loc;
        gi   = 0;
        base = '0;
        if (ng == 0) begin
            spc = 64'd1;
        end else begin
            clean &= grp_known[0];
            spc = {32'd0, grp_spc_tbl[0]};
        end
        for (nc = 0; nc < nch; nc++) begin
            // next group starts at chunk first-1; first chunk zero wraps and never matches
            if (gi + 1 < ng) begin
                clean &= grp_known[gi + 1];
                if (nc == grp_first_tbl[gi + 1] - 32'd1) begin
                    gi++;
                    spc = {32'd0, grp_spc_tbl[gi]};
                end
            end
            if ({32'd0, s} < base + spc) begin
                sum = '0;
                for (k = base[31:0]; k < s; k++) begin
                    clean &= size_known[k];
                    sum += {32'd0, size_tbl[k]};
                end
                clean &= offset_known[nc];
                loc.found       = 1'b1;
                loc.byte_offset = offset_tbl[nc] + sum;
                return loc;
            end
            base += spc;
        end
        return loc;
    endfunction

    task automatic send_word(input t_in_word w);
        bit        clean;
        t_out_word loc;
        i_in_data  <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_counted++;
        case (w.kind)
            KIND_WR_SIZE: begin
                size_tbl[w.table_index]   = w.entry_value[31:0];
                size_known[w.table_index] = 1'b1;
                loads_done++;
            end
            KIND_WR_CHUNK: begin
                if (w.table_index < CHUNK_DEPTH) begin
                    offset_tbl[w.table_index[9:0]]   = w.entry_value;
                    offset_known[w.table_index[9:0]] = 1'b1;
                    loads_done++;
                end
            end
            KIND_WR_GROUP: begin
                if (w.table_index < GROUP_DEPTH) begin
                    grp_first_tbl[w.table_index[5:0]] = w.entry_value[31:0];
                    grp_spc_tbl[w.table_index[5:0]]   = w.group_samples;
                    grp_known[w.table_index[5:0]]     = 1'b1;
                    loads_done++;
                end
            end
            KIND_LOOKUP: begin
                loc = locate_sample(w.sample_number, clean);
                located_q.push_back(loc);
                hits += loc.found;
                lookups_done++;
            end
            default: ;
        endcase
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 25 : 4))
                    @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic load_entry(input logic [1:0] kind, input int unsigned idx,
                              input bit [63:0] val, input bit [31:0] per_chunk);
        t_in_word w;
        w.kind          = kind;
        w.table_index   = idx[11:0];
        w.entry_value   = val;
        w.group_samples = per_chunk;
        w.sample_number = $urandom;
        send_word(w);
    endtask

    task automatic look_up_sample(input bit [31:0] s);
        t_in_word w;
        bit       clean;
        void'(locate_sample(s, clean));
        // a walk that would touch an entry never loaded is swapped for a sample past the table
        if (!clean)
            s = ((n_samples_reg > SIZE_DEPTH) ? SIZE_DEPTH : n_samples_reg) + $urandom_range(0, 7);
        w.kind          = KIND_LOOKUP;
        w.table_index   = $urandom;
        w.entry_value   = {$urandom, $urandom};
        w.group_samples = $urandom;
        w.sample_number = s;
        send_word(w);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (located_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_counts(input int unsigned ns, input int unsigned nch,
                              input int unsigned ng);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SAMPLE_COUNT;
        i_cfg_data  <= CFG_DATA_W'(ns);
        @(posedge i_clk);
        i_cfg_index <= CFG_CHUNK_COUNT;
        i_cfg_data  <= CFG_DATA_W'(nch);
        @(posedge i_clk);
        i_cfg_index <= CFG_GROUP_COUNT;
        i_cfg_data  <= CFG_DATA_W'(ng);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_samples_reg = ns[12:0];
        n_chunks_reg  = nch[10:0];
        n_groups_reg  = ng[6:0];
        settings_used++;
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        stall_tick++;
        case (ready_mode)
            RX_ALWAYS:   i_out_ready <= 1'b1;
            RX_RANDOM:   i_out_ready <= ($urandom_range(0, 99) < 65);
            RX_CHOPPY:   i_out_ready <= ((stall_tick % 7) >= 3);
            default:     i_out_ready <= ((stall_tick % 48) >= 36);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (located_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected word: found=%0b offset=%h size=%h", $time,
                             o_out_data.found, o_out_data.byte_offset, o_out_data.frame_size);
            end else begin
                want = located_q.pop_front();
                if (o_out_data.found !== want.found ||
                    o_out_data.byte_offset !== want.byte_offset ||
                    o_out_data.frame_size !== want.frame_size) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: expected found=%0b offset=%h size=%h", $time,
                                 want.found, want.byte_offset, want.frame_size);
                        $display("          got      found=%0b offset=%h size=%h",
                                 o_out_data.found, o_out_data.byte_offset,
                                 o_out_data.frame_size);
                    end
                end
            end
        end
    end

    // all counts zero after reset, and loads aimed past the chunk and group tables
    task automatic test_idle_tables();
        steady     = 1'b1;
        ready_mode = RX_ALWAYS;
        look_up_sample(32'd0);
        look_up_sample(32'hFFFF_FFFF);
        load_entry(KIND_WR_CHUNK, 4095, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
        load_entry(KIND_WR_GROUP, 4095, {$urandom, $urandom}, 32'hFFFF_FFFF);
        load_entry(KIND_WR_GROUP, GROUP_DEPTH, {$urandom, $urandom}, $urandom);
    endtask

    // group changes, an empty chunk, a group that starts at chunk zero, offset wrap
    task automatic test_directed_walk();
        steady     = 1'b0;
        ready_mode = RX_CHOPPY;
        set_counts(6, 5, 4);
        load_entry(KIND_WR_SIZE, 0, 64'hFFFF_FFFF_0000_0000, $urandom);
        load_entry(KIND_WR_SIZE, 1, {$urandom, 32'd100}, $urandom);
        load_entry(KIND_WR_SIZE, 2, {$urandom, 32'd37}, $urandom);
        load_entry(KIND_WR_SIZE, 3, {$urandom, 32'd4000}, $urandom);
        load_entry(KIND_WR_SIZE, 4, 64'h0000_0000_FFFF_FFFF, $urandom);
        load_entry(KIND_WR_SIZE, 5, {$urandom, 32'd12}, $urandom);
        load_entry(KIND_WR_CHUNK, 0, 64'd0, $urandom);
        load_entry(KIND_WR_CHUNK, 1, 64'h1000, $urandom);
        load_entry(KIND_WR_CHUNK, 2, 64'h2000, $urandom);
        load_entry(KIND_WR_CHUNK, 3, 64'h0000_0001_0000_0000, $urandom);
        load_entry(KIND_WR_CHUNK, 4, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
        load_entry(KIND_WR_GROUP, 0, {$urandom, 32'd1}, 32'd2);
        load_entry(KIND_WR_GROUP, 1, {$urandom, 32'd2}, 32'd0);
        load_entry(KIND_WR_GROUP, 2, {$urandom, 32'd4}, 32'd2);
        load_entry(KIND_WR_GROUP, 3, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF);
        look_up_sample(32'd0);
        look_up_sample(32'd1);
        look_up_sample(32'd3);
        look_up_sample(32'd5);
        look_up_sample(32'd6);
    endtask

    task automatic test_no_groups_empty_chunks();
        ready_mode = RX_RANDOM;
        set_counts(6, 3, 0);
        look_up_sample(32'd2);
        look_up_sample(32'd4);
        set_counts(6, 0, 4);
        look_up_sample(32'd1);
    endtask

    // counts above the table depths act as the depths; longest walks
    task automatic test_count_clamp();
        int unsigned g;
        ready_mode = RX_SLUGGISH;
        set_counts(8191, 2047, 0);
        load_entry(KIND_WR_SIZE, 1023, {$urandom, $urandom}, $urandom);
        load_entry(KIND_WR_CHUNK, 1023, {$urandom, $urandom}, $urandom);
        load_entry(KIND_WR_SIZE, 4095, {$urandom, $urandom}, $urandom);
        look_up_sample(32'd1023);
        look_up_sample(32'd4095);
        look_up_sample(32'd4096);
        look_up_sample(32'd1);
        set_counts(4096, 1024, 127);
        // sixteen chunks per group, four samples per chunk, fills exactly 1024 chunks
        for (g = 0; g < GROUP_DEPTH; g++)
            load_entry(KIND_WR_GROUP, g, {$urandom, 32'(1 + 16 * g)}, 32'd4);
        for (g = 4092; g < 4095; g++)
            load_entry(KIND_WR_SIZE, g, {$urandom, $urandom}, $urandom);
        look_up_sample(32'd4095);
        look_up_sample(32'd4093);
        look_up_sample(32'd2);
        look_up_sample(32'd4096);
    endtask

    task automatic test_random_tables();
        int unsigned ns, ns_eff, nch, ng, n, asks, grp_start, pause_at, phase;
        bit          wild;
        bit [31:0]   s;
        phase = 0;
        while (words_counted < ITEM_TARGET) begin
            wild = ($urandom_range(0, 7) == 0);
            if (wild) begin
                ns  = $urandom_range(SIZE_DEPTH, 8191);
                nch = $urandom_range(0, 2047);
                ng  = $urandom_range(0, 127);
            end else begin
                ns  = $urandom_range(0, 24);
                nch = $urandom_range(0, 12);
                ng  = $urandom_range(0, 5);
            end
            ns_eff     = (ns > SIZE_DEPTH) ? SIZE_DEPTH : ns;
            ready_mode = t_rx_mode'($urandom_range(0, 3));
            steady     = ($urandom_range(0, 3) == 0);
            set_counts(ns, nch, ng);
            if (!wild) begin
                grp_start = 1;
                for (n = 0; n < ng; n++) begin
                    load_entry(KIND_WR_GROUP, n,
                               ($urandom_range(0, 9) == 0) ? {$urandom, 32'd0}
                                                           : {$urandom, 32'(grp_start)},
                               ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4));
                    grp_start += $urandom_range(0, 3);
                end
                for (n = 0; n < nch; n++)
                    load_entry(KIND_WR_CHUNK, n,
                               ($urandom_range(0, 4) == 0) ? {32'hFFFF_FFFF, $urandom}
                                                           : {$urandom, $urandom},
                               $urandom);
                for (n = 0; n < ns; n++)
                    load_entry(KIND_WR_SIZE, n,
                               {$urandom, ($urandom_range(0, 3) == 0)
                                          ? $urandom : 32'($urandom_range(0, 2000))},
                               $urandom);
            end
            asks     = $urandom_range(8, 16);
            pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(1, asks - 1)
                                                                  : asks;
            for (n = 0; n < asks; n++) begin
                // hold the sender until every located word is back
                if (n == pause_at) wait_drained();
                if ($urandom_range(0, 6) == 0)
                    load_entry(2'($urandom_range(0, 2)), $urandom_range(0, 4095),
                               {$urandom, $urandom}, $urandom);
                case ($urandom_range(0, 9))
                    0:       s = $urandom;
                    1:       s = ns_eff;
                    2:       s = (ns_eff == 0) ? 32'd0 : ns_eff - 1;
                    default: s = $urandom_range(0, wild ? 64 : ns_eff + 1);
                endcase
                look_up_sample(s);
            end
            phase++;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_tables();
        test_directed_walk();
        test_no_groups_empty_chunks();
        test_count_clamp();
        test_random_tables();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d table loads and %0d lookups over %0d count settings",
                 loads_done, lookups_done, settings_used);
        $display("summary: %0d lookups located a frame, %0d did not, %0d bad result words",
                 hits, lookups_done - hits, mismatches);
        if (mismatches == 0 && located_q.size() == 0) begin
            $display("tb_sample_table_frame_locator_unit: done, clean");
        end else begin
            $display("tb_sample_table_frame_locator_unit: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/stfl_pkg.sv
hw/rtl/sample_table_frame_locator_unit.sv
verif/tb_sample_table_frame_locator_unit.sv
